// File: sv/lpr_pkg.sv
// Shared constants and types for the LRU page replacement unit.
package lpr_pkg;

  localparam int FRAMES_DEF = 8;
  localparam int PAGE_W     = 16;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 32;
  localparam int IDX_OUT_W  = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic              vict_valid;
    logic [PAGE_W-1:0] vict_page;
  } scan_res_t;

endpackage

// File: sv/lpr_frame_mem.sv
// Page number store for the frames: one write port, one registered read port.
module lpr_frame_mem #(
  parameter int DEPTH = lpr_pkg::FRAMES_DEF,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [lpr_pkg::PAGE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [lpr_pkg::PAGE_W-1:0] rdata
);
  import lpr_pkg::*;

  logic [PAGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lpr_scan.sv
// Shared compare unit: per-frame match search and least-recent frame tracking.
module lpr_scan #(
  parameter int IW = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpr_pkg::scan_ctl_t         ctl,
  input  logic [lpr_pkg::PAGE_W-1:0] req_page,
  input  logic [lpr_pkg::PAGE_W-1:0] cand_page,
  input  logic                       cand_valid,
  input  logic [IW-1:0]              cand_rank,
  input  logic [IW-1:0]              cand_idx,
  output lpr_pkg::scan_res_t         res,
  output logic [IW-1:0]              slot
);
  import lpr_pkg::*;

  logic              hit_r;
  logic              have_r;
  logic [IW-1:0]     hit_slot_r;
  logic [IW-1:0]     min_slot_r;
  logic [IW-1:0]     min_rank_r;
  logic              vict_valid_r;
  logic [PAGE_W-1:0] vict_page_r;
  logic              match;
  logic              older;

  assign match = cand_valid && (cand_page == req_page);
  assign older = !have_r || (cand_rank < min_rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      hit_r  <= 1'b0;
      have_r <= 1'b0;
    end else if (ctl.step) begin
      have_r <= 1'b1;
      if (match && !hit_r) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && !ctl.clear) begin
      if (match && !hit_r) begin
        hit_slot_r <= cand_idx;
      end
      if (older) begin
        min_rank_r   <= cand_rank;
        min_slot_r   <= cand_idx;
        vict_valid_r <= cand_valid;
        vict_page_r  <= cand_page;
      end
    end
  end

  assign res.hit        = hit_r;
  assign res.vict_valid = vict_valid_r;
  assign res.vict_page  = vict_page_r;
  assign slot           = hit_r ? hit_slot_r : min_slot_r;

endmodule

// File: sv/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit: sequencer, frame state and result register.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | in_page
//   out_    | output    | out_valid / out_stall | out_hit, out_frame_index, out_evicted_valid,
//           |           |                       | out_evicted_page, out_hit_total, out_miss_total
//   cfg_    | input     | cfg_we                | cfg_wdata
//
// Each word is accepted in the idle state, then the scan state streams the n active frames
// (n being the active frame count) through the shared compare unit behind the registered page
// store read, and the write state commits the result.
// Reset is synchronous: all frames empty, ranks equal to frame index, totals zero, count 8.
// A stalled result holds in the output register; the next word is taken while it waits, and
// commit waits until the register is free.
module lru_page_replacement_unit #(
  parameter int FRAMES = lpr_pkg::FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpr_pkg::PAGE_W-1:0]    in_page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lpr_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic                          out_evicted_valid,
  output logic [lpr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [lpr_pkg::CNT_W-1:0]     out_hit_total,
  output logic [lpr_pkg::CNT_W-1:0]     out_miss_total,
  input  logic                          cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]     cfg_wdata
);
  import lpr_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [CW-1:0] FR_CNT  = CW'(FRAMES);
  localparam logic [7:0]    FR8     = 8'(FRAMES);
  localparam logic [IW-1:0] TOP_RNK = IW'(FRAMES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]     q_idx_r, q_idx_nxt;
  logic              q_v_r, q_v_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [PAGE_W-1:0] page_r;
  logic [CFG_W-1:0]  fiu_r;
  logic [7:0]        fiu8;
  logic              valid_r [FRAMES];
  logic [IW-1:0]     rank_r  [FRAMES];
  logic [IW-1:0]     rank_nxt [FRAMES];
  logic [CNT_W-1:0]  hit_cnt_r, miss_cnt_r;
  logic [CNT_W-1:0]  hit_cnt_nxt, miss_cnt_nxt;
  logic              out_valid_r;

  scan_ctl_t         ctl;
  scan_res_t         res;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     old_rank;
  logic [PAGE_W-1:0] rd_page;
  logic              fire_in;
  logic              out_free;
  logic              commit;

  assign fire_in  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  assign fiu8 = {4'd0, fiu_r};
  always_comb begin
    if (fiu_r == '0) begin
      cnt_nxt = CW'(1);
    end else if (fiu8 > FR8) begin
      cnt_nxt = FR_CNT;
    end else begin
      cnt_nxt = CW'(fiu8);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    q_idx_nxt  = q_idx_r;
    q_v_nxt    = 1'b0;
    ctl        = '0;
    commit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (fire_in) begin
          ctl.clear  = 1'b1;
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.step = q_v_r;
        if (rd_idx_r != cnt_r) begin
          q_v_nxt    = 1'b1;
          q_idx_nxt  = rd_idx_r[IW-1:0];
          rd_idx_nxt = rd_idx_r + CW'(1);
        end else if (!q_v_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  lpr_frame_mem #(
    .DEPTH (FRAMES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (commit && !res.hit),
    .waddr (slot),
    .wdata (page_r),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (rd_page)
  );

  lpr_scan #(
    .IW (IW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .req_page   (page_r),
    .cand_page  (rd_page),
    .cand_valid (valid_r[q_idx_r]),
    .cand_rank  (rank_r[q_idx_r]),
    .cand_idx   (q_idx_r),
    .res        (res),
    .slot       (slot)
  );

  assign old_rank = rank_r[slot];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (commit) begin
        if (IW'(i) == slot) begin
          rank_nxt[i] = TOP_RNK;
        end else if (rank_r[i] > old_rank) begin
          rank_nxt[i] = rank_r[i] - IW'(1);
        end
      end
    end
  end

  assign hit_cnt_nxt  = (res.hit && hit_cnt_r != '1) ? hit_cnt_r + CNT_W'(1) : hit_cnt_r;
  assign miss_cnt_nxt = (!res.hit && miss_cnt_r != '1) ? miss_cnt_r + CNT_W'(1) : miss_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      q_idx_r     <= '0;
      q_v_r       <= 1'b0;
      fiu_r       <= CFG_RESET;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= IW'(i);
      end
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      q_idx_r  <= q_idx_nxt;
      q_v_r    <= q_v_nxt;
      if (cfg_we) begin
        fiu_r <= cfg_wdata;
      end
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
        if (!res.hit) begin
          valid_r[slot] <= 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      page_r <= in_page;
      cnt_r  <= cnt_nxt;
    end
    if (commit) begin
      out_hit           <= res.hit;
      out_frame_index   <= IDX_OUT_W'(slot);
      out_evicted_valid <= !res.hit && res.vict_valid;
      out_evicted_page  <= (!res.hit && res.vict_valid) ? res.vict_page : '0;
      out_hit_total     <= hit_cnt_nxt;
      out_miss_total    <= miss_cnt_nxt;
    end
  end

endmodule

// File: sv/lpr_checker.sv
// Port-level assertions for the LRU page replacement unit, bound to the top level.
module lpr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic [lpr_pkg::IDX_OUT_W-1:0] out_frame_index,
  input logic                          out_evicted_valid,
  input logic [lpr_pkg::PAGE_W-1:0]    out_evicted_page,
  input logic [lpr_pkg::CNT_W-1:0]     out_hit_total,
  input logic [lpr_pkg::CNT_W-1:0]     out_miss_total
);
  import lpr_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_index)
      && $stable(out_hit_total) && $stable(out_miss_total))
    else $error("stalled result word changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement_unit lpr_checker u_lpr_checker (.*);

// File: bench/testbench.sv
// Self-checking testbench for the LRU page replacement unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 137;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } page_result_t;

  class lru_shadow;
    bit [PAGE_W-1:0]    frame_page [FRAMES_DEF];
    bit                 frame_full [FRAMES_DEF];
    bit [IDX_OUT_W-1:0] frame_rank [FRAMES_DEF];
    bit [CNT_W-1:0]     hits;
    bit [CNT_W-1:0]     misses;
    bit [CFG_W-1:0]     frame_count;
    page_result_t       pending_results [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < FRAMES_DEF; i++) begin
        frame_page[i] = '0;
        frame_full[i] = 1'b0;
        frame_rank[i] = IDX_OUT_W'(i);
      end
      hits        = '0;
      misses      = '0;
      frame_count = CFG_RESET;
      mismatches  = 0;
    endfunction

    function void set_frames(bit [CFG_W-1:0] v);
      frame_count = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(bit [PAGE_W-1:0] req);
      page_result_t r;
      int n;
      int slot;
      bit [IDX_OUT_W-1:0] old_rank;
      n = (frame_count == 0) ? 1 : int'(frame_count);
      if (n > FRAMES_DEF) n = FRAMES_DEF;
      r = '0;
      slot = 0;
      for (int i = 0; i < n; i++) begin
        if (!r.hit && frame_full[i] && frame_page[i] == req) begin
          r.hit = 1'b1;
          slot = i;
        end
      end
      if (r.hit) begin
        if (hits != '1) hits++;
      end else begin
        for (int i = 1; i < n; i++) begin
          if (frame_rank[i] < frame_rank[slot]) slot = i;
        end
        if (frame_full[slot]) begin
          r.evicted_valid = 1'b1;
          r.evicted_page  = frame_page[slot];
        end
        frame_page[slot] = req;
        frame_full[slot] = 1'b1;
        if (misses != '1) misses++;
      end
      old_rank = frame_rank[slot];
      for (int i = 0; i < FRAMES_DEF; i++) begin
        if (frame_rank[i] > old_rank) frame_rank[i]--;
      end
      frame_rank[slot] = IDX_OUT_W'(FRAMES_DEF - 1);
      r.frame_index = IDX_OUT_W'(slot);
      r.hit_total   = hits;
      r.miss_total  = misses;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(page_result_t got);
      page_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
      compare_field("frame_index", CNT_W'(want.frame_index), CNT_W'(got.frame_index));
      compare_field("evicted_valid", CNT_W'(want.evicted_valid), CNT_W'(got.evicted_valid));
      compare_field("evicted_page", CNT_W'(want.evicted_page), CNT_W'(got.evicted_page));
      compare_field("hit_total", want.hit_total, got.hit_total);
      compare_field("miss_total", want.miss_total, got.miss_total);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_W-1:0]    in_page;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_hit;
  logic [IDX_OUT_W-1:0] out_frame_index;
  logic                 out_evicted_valid;
  logic [PAGE_W-1:0]    out_evicted_page;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_miss_total;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;
  int quiet_cycles;

  lru_shadow shadow = new();

  lru_page_replacement_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) shadow.note_request(in_page);
      if (out_valid && !out_stall) begin
        shadow.check_result('{out_hit, out_frame_index, out_evicted_valid,
                              out_evicted_page, out_hit_total, out_miss_total});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold off for a long stretch on request, otherwise stall at random unless rx_steady is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall   = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !rx_steady && ($urandom_range(99) < 30);
    end
  end

  task automatic send_request(input logic [PAGE_W-1:0] req);
    @(negedge clk);
    while (!tx_steady && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      in_page  = PAGE_W'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_page  = req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    shadow.set_frames(v);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] pool [12];
    logic [CFG_W-1:0]  count_plan [6];
    int                pool_size;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_page     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_hold_req = 1'b0;
    count_plan  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd2};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill all eight frames, hit, then evict the oldest
    send_request(16'h0000);
    send_request(16'h0000);
    send_request(16'hFFFF);
    for (int p = 1; p <= 6; p++) send_request(PAGE_W'(p));
    send_request(16'h0000);
    send_request(16'h0007);
    send_request(16'hFFFF);
    // single frame
    write_frame_count(4'd1);
    send_request(16'h5555);
    send_request(16'h5555);
    send_request(16'hAAAA);
    // zero acts as one
    write_frame_count(4'd0);
    send_request(16'hAAAA);
    send_request(16'h0003);
    // above the frame count acts as all frames; left-out frames rejoin
    write_frame_count(4'd15);
    send_request(16'h0002);
    send_request(16'h0007);
    send_request(16'hAAAA);
    send_request(16'h8001);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_frame_count(ph < 6 ? count_plan[ph] : CFG_W'($urandom_range(15)));
      tx_steady = (ph == 3);
      rx_steady = (ph == 3);
      pool_size = $urandom_range(12, 1);
      for (int k = 0; k < pool_size; k++) pool[k] = PAGE_W'($urandom);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if ((ph == 2 || ph == 7) && w == 20) rx_hold_req = 1'b1;
        if (ph == 5 && w == 60) drain_results();
        if ($urandom_range(99) < 75) send_request(pool[$urandom_range(pool_size - 1)]);
        else send_request(PAGE_W'($urandom));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
